/* hdl/nsr_pkg.sv */
// Shared constants and types for the Newton square root block.
package nsr_pkg;

    // Fixed field widths
    localparam int OPER_W  = 32;
    localparam int ROOT_W  = 25;
    localparam int COUNT_W = 6;
    localparam int TOL_W   = 16;

    // Register reset value and parameter defaults
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_ITER_DEF  = 32;

    // Saturation limits of the result fields
    localparam logic [OPER_W-1:0]  ROOT_MAX  = OPER_W'({ROOT_W{1'b1}});
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Sequencer to divider
    typedef struct packed {
        logic              start;
        logic [OPER_W-1:0] dividend;
        logic [OPER_W-1:0] divisor;
    } div_req_t;

    // Divider to sequencer
    typedef struct packed {
        logic              done;
        logic [OPER_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* hdl/nsr_if.sv */
// Valid/ready channel interfaces for operand and result words.
interface nsr_operand_if;
    import nsr_pkg::*;

    logic              valid;
    logic              ready;
    logic [OPER_W-1:0] operand;

    modport source (output valid, output operand, input ready);
    modport sink   (input valid, input operand, output ready);
endinterface

interface nsr_result_if;
    import nsr_pkg::*;

    logic               valid;
    logic               ready;
    logic [ROOT_W-1:0]  root;
    logic [COUNT_W-1:0] step_count;
    logic               limit_reached;

    modport source (output valid, output root, output step_count, output limit_reached,
                    input ready);
    modport sink   (input valid, input root, input step_count, input limit_reached,
                    output ready);
endinterface

/* hdl/nsr_divider.sv */
// Bit-serial restoring divider: (dividend << FRAC_BITS) / divisor, one bit per cycle.
module nsr_divider #(
    parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  nsr_pkg::div_req_t div_req,
    output nsr_pkg::div_rsp_t div_rsp
);
    import nsr_pkg::*;

    localparam int TOTAL = OPER_W + FRAC_BITS;
    localparam int CNT_W = $clog2(TOTAL);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t            state_reg, state_next;
    logic [OPER_W-1:0] num_reg, num_next;
    logic [OPER_W-1:0] rem_reg, rem_next;
    logic [OPER_W-1:0] quo_reg, quo_next;
    logic [OPER_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;

    logic [OPER_W:0]   trial;
    logic [OPER_W:0]   diff;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_reg, num_reg[OPER_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (div_req.start)
                begin
                    num_next   = div_req.dividend;
                    rem_next   = '0;
                    quo_next   = '0;
                    div_next   = (div_req.divisor == '0) ? OPER_W'(1) : div_req.divisor;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // zeros enter behind the dividend and supply the fraction bits
                num_next = {num_reg[OPER_W-2:0], 1'b0};
                if (!diff[OPER_W])
                begin
                    rem_next = diff[OPER_W-1:0];
                    quo_next = {quo_reg[OPER_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[OPER_W-1:0];
                    quo_next = {quo_reg[OPER_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TOTAL - 1))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            num_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            div_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            num_reg   <= num_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            div_reg   <= div_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = quo_reg;

endmodule

/* hdl/nsr_ctrl.sv */
// Newton iteration sequencer: guess update, convergence test and result register.
module nsr_ctrl #(
    parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF,
    parameter int MAX_ITER  = nsr_pkg::MAX_ITER_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [nsr_pkg::TOL_W-1:0]  tolerance,
    nsr_operand_if.sink                request,
    nsr_result_if.source               result,
    output nsr_pkg::div_req_t          div_req,
    input  nsr_pkg::div_rsp_t          div_rsp
);
    import nsr_pkg::*;

    localparam int STEP_W = $clog2(MAX_ITER + 1);
    localparam int SAT_W  = (STEP_W > COUNT_W) ? STEP_W : COUNT_W;
    localparam logic [OPER_W-1:0] GUESS_ONE = OPER_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_UPD, ST_DIFF, ST_TEST, ST_DONE} state_t;

    state_t             state_reg, state_next;
    logic [OPER_W-1:0]  op_reg, op_next;
    logic [OPER_W-1:0]  guess_reg, guess_next;
    logic [OPER_W-1:0]  quo_reg, quo_next;
    logic [OPER_W-1:0]  new_reg, new_next;
    logic [OPER_W-1:0]  diff_reg, diff_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               limit_reg, limit_next;
    logic               start_reg, start_next;
    logic               res_valid_reg, res_valid_next;
    logic [ROOT_W-1:0]  res_root_reg, res_root_next;
    logic [COUNT_W-1:0] res_count_reg, res_count_next;
    logic               res_limit_reg, res_limit_next;

    logic [OPER_W:0]    sum;
    logic [SAT_W-1:0]   step_wide;

    assign sum       = {1'b0, guess_reg} + {1'b0, quo_reg};
    assign step_wide = SAT_W'(step_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        guess_next     = guess_reg;
        quo_next       = quo_reg;
        new_next       = new_reg;
        diff_next      = diff_reg;
        step_next      = step_reg;
        limit_next     = limit_reg;
        start_next     = 1'b0;
        res_root_next  = res_root_reg;
        res_count_next = res_count_reg;
        res_limit_next = res_limit_reg;
        // drop the output word once taken
        res_valid_next = res_valid_reg && !result.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    if (request.operand == '0)
                    begin
                        new_next   = '0;
                        step_next  = '0;
                        limit_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        op_next    = request.operand;
                        guess_next = GUESS_ONE;
                        step_next  = '0;
                        start_next = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    quo_next   = div_rsp.quotient;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                // average guess and quotient, truncating
                new_next   = sum[OPER_W:1];
                step_next  = step_reg + STEP_W'(1);
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                diff_next  = (new_reg >= guess_reg) ? (new_reg - guess_reg)
                                                    : (guess_reg - new_reg);
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (diff_reg <= OPER_W'(tolerance))
                begin
                    limit_next = 1'b0;
                    state_next = ST_DONE;
                end
                else if (step_reg == STEP_W'(MAX_ITER))
                begin
                    limit_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    // advance to the next step
                    guess_next = new_reg;
                    start_next = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DONE:
            begin
                // load the output word once the slot is free, saturating wide fields
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    res_root_next  = (new_reg > ROOT_MAX) ? ROOT_MAX[ROOT_W-1:0]
                                                          : new_reg[ROOT_W-1:0];
                    res_count_next = (step_wide > SAT_W'(COUNT_MAX)) ? COUNT_MAX
                                                                     : step_wide[COUNT_W-1:0];
                    res_limit_next = limit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= '0;
            guess_reg     <= '0;
            quo_reg       <= '0;
            new_reg       <= '0;
            diff_reg      <= '0;
            step_reg      <= '0;
            limit_reg     <= 1'b0;
            start_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            res_root_reg  <= '0;
            res_count_reg <= '0;
            res_limit_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            guess_reg     <= guess_next;
            quo_reg       <= quo_next;
            new_reg       <= new_next;
            diff_reg      <= diff_next;
            step_reg      <= step_next;
            limit_reg     <= limit_next;
            start_reg     <= start_next;
            res_valid_reg <= res_valid_next;
            res_root_reg  <= res_root_next;
            res_count_reg <= res_count_next;
            res_limit_reg <= res_limit_next;
        end
    end

    assign request.ready = (state_reg == ST_IDLE);

    assign result.valid         = res_valid_reg;
    assign result.root          = res_root_reg;
    assign result.step_count    = res_count_reg;
    assign result.limit_reached = res_limit_reg;

    assign div_req.start    = start_reg;
    assign div_req.dividend = op_reg;
    assign div_req.divisor  = guess_reg;

endmodule

/* hdl/newton_square_root_top.sv */
// Top level of the Newton square root block: tolerance register, sequencer and divider.
//
// Takes an unsigned fixed-point operand with FRAC_BITS fraction bits and returns its
// square root by Newton iteration, starting from a guess of 1.0 and stopping once the
// guess moves by no more than stop_tolerance LSBs or after MAX_ITER steps (then
// limit_reached is set). A zero operand returns zero with no steps. Each Newton step
// runs one division on a bit-serial divider that retires one quotient bit per cycle.
// One operand is in work at a time; the next is taken as soon as the result word has
// been moved into the output register, even while that word still waits to be taken.
// Write stop_tolerance through cfg_we/cfg_wdata only while the block is idle.
module newton_square_root_top #(
    parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF,
    parameter int MAX_ITER  = nsr_pkg::MAX_ITER_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [nsr_pkg::TOL_W-1:0] cfg_wdata,
    nsr_operand_if.sink               request,
    nsr_result_if.source              result
);
    import nsr_pkg::*;

    logic [TOL_W-1:0] tol_reg;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    // Hold the stop tolerance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            tol_reg <= cfg_wdata;
        end
    end

    nsr_ctrl #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_ITER  (MAX_ITER)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tolerance (tol_reg),
        .request   (request),
        .result    (result),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    nsr_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

endmodule
